// File: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the SSD stereo disparity core.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Default geometry of the core
  localparam int WINDOW_RADIUS_DEF   = 9;
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int DISPARITY_LIMIT_DEF = 128;
  localparam int HEIGHT_LIMIT        = 1024;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CODE_W  = 8;
  localparam int COST_W  = 25;
  localparam int FW_W    = 11;
  localparam int FH_W    = 11;
  localparam int MD_W    = 7;
  localparam int SCALE_W = 8;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // Register map (word index)
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_MAX_DISPARITY = 2'd2;
  localparam logic [1:0] REG_OUTPUT_SCALE  = 2'd3;

  // Register reset values
  localparam logic [FW_W-1:0]    FRAME_WIDTH_RST   = 11'd640;
  localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST  = 11'd480;
  localparam logic [MD_W-1:0]    MAX_DISPARITY_RST = 7'd96;
  localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST  = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SHIFT,
    ST_DONE
  } ssd_state_e;

  // Broadcast control for the row of disparity cells
  typedef struct packed {
    logic             clear;
    logic             acc_en;
    logic             r_shift;
    logic             shift_out;
    logic [PIX_W-1:0] l_pix;
  } ssd_cell_ctrl_t;

endpackage

// File: rtl/ssd_cell.sv
// ----------------------------------------------------------------------------
// ssd_cell
// One disparity cell: holds a shifted right pixel and a cost accumulator.
// ----------------------------------------------------------------------------
module ssd_cell #(
  parameter int ACC_W = 25
) (
  input  logic                       clk_i,
  input  ssd_pkg::ssd_cell_ctrl_t    ctrl_i,
  input  logic [ssd_pkg::PIX_W-1:0]  r_i,
  input  logic [ACC_W-1:0]           acc_i,
  output logic [ssd_pkg::PIX_W-1:0]  r_o,
  output logic [ACC_W-1:0]           acc_o
);
  import ssd_pkg::*;

  logic [PIX_W-1:0]   r_q;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PIX_W-1:0]   diff;
  logic [2*PIX_W-1:0] sq;

  always_comb begin
    diff = (ctrl_i.l_pix > r_q) ? ctrl_i.l_pix - r_q : r_q - ctrl_i.l_pix;
    sq   = {{PIX_W{1'b0}}, diff} * {{PIX_W{1'b0}}, diff};
  end

  always_comb begin
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.shift_out) begin
      acc_d = acc_i;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + ACC_W'(sq);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.r_shift) begin
      r_q <= r_i;
    end
  end

  assign r_o   = r_q;
  assign acc_o = acc_q;

endmodule

// File: rtl/ssd_line_store.sv
// ----------------------------------------------------------------------------
// ssd_line_store
// Circular store of image rows, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module ssd_line_store #(
  parameter int ROWS  = 20,
  parameter int WIDTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ROWS)-1:0]    wr_slot_i,
  input  logic [$clog2(WIDTH)-1:0]   wr_col_i,
  input  logic [ssd_pkg::PIX_W-1:0]  wr_data_i,
  input  logic [$clog2(ROWS)-1:0]    rd_slot_i,
  input  logic [$clog2(WIDTH)-1:0]   rd_col_i,
  output logic [ssd_pkg::PIX_W-1:0]  rd_data_o
);
  import ssd_pkg::*;

  localparam int DEPTH  = ROWS * WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign wr_addr = ADDR_W'(wr_slot_i) * ADDR_W'(WIDTH) + ADDR_W'(wr_col_i);
  assign rd_addr = ADDR_W'(rd_slot_i) * ADDR_W'(WIDTH) + ADDR_W'(rd_col_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr];
  end

endmodule

// File: rtl/ssd_stereo_disparity_core.sv
// ----------------------------------------------------------------------------
// ssd_stereo_disparity_core
// SSD block-matching stereo disparity over a clipped square window.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  input    | in        | in_valid_i / in_ready_o| left_pixel, right_pixel,
//           |           |                        | is_padding
//  output   | out       | out_valid_o/out_ready_i| disparity_code, best_cost,
//           |           |                        | frame_end
//  config   | in        | APB write/read         | 4 registers at 4*index
//
//  An item that yields no result is taken without leaving the idle state. An
//  item that yields a result starts a scan of its clipped window: each window
//  row is streamed through the cell row once, one column a cycle, after
//  DISPARITY_LIMIT-1 lead columns. Reset clears counters and control only;
//  the line stores need no clearing. A finished result waits in the output
//  register while the next item is taken; the block stalls in its last step
//  only if that register is full and not being read.
//
module ssd_stereo_disparity_core #(
  parameter int WINDOW_RADIUS   = ssd_pkg::WINDOW_RADIUS_DEF,
  parameter int MAX_WIDTH       = ssd_pkg::MAX_WIDTH_DEF,
  parameter int DISPARITY_LIMIT = ssd_pkg::DISPARITY_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ssd_pkg::PIX_W-1:0]     left_pixel_i,
  input  logic [ssd_pkg::PIX_W-1:0]     right_pixel_i,
  input  logic                          is_padding_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ssd_pkg::CODE_W-1:0]    disparity_code_o,
  output logic [ssd_pkg::COST_W-1:0]    best_cost_o,
  output logic                          frame_end_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssd_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssd_pkg::DATA_W-1:0]    pwdata,
  output logic [ssd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ssd_pkg::*;

  localparam int STORE_ROWS = 2 * WINDOW_RADIUS + 2;
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
  localparam int HGT_W      = $clog2(HEIGHT_LIMIT + 1);
  localparam int DISP_W     = $clog2(DISPARITY_LIMIT);
  localparam int XW         = ((COL_W > DISP_W) ? COL_W : DISP_W) + 1;
  localparam int ITEM_W     = $clog2(MAX_WIDTH * HEIGHT_LIMIT
                                     + WINDOW_RADIUS * MAX_WIDTH + WINDOW_RADIUS + 2);
  localparam int WIN        = 2 * WINDOW_RADIUS + 1;
  localparam int ACC_W      = $clog2(WIN * WIN * 65025 + 1);
  localparam int PROD_W     = DISP_W + SCALE_W;

  // Configuration registers
  logic [FW_W-1:0]    fw_q;
  logic [FH_W-1:0]    fh_q;
  logic [MD_W-1:0]    md_q;
  logic [SCALE_W-1:0] scale_q;

  // Frame position
  logic [ITEM_W-1:0]  items_q;
  logic [COL_W-1:0]   wr_col_q;
  logic [SLOT_W-1:0]  wr_slot_q;
  logic [ROW_W-1:0]   orow_q;
  logic [COL_W-1:0]   ocol_q;
  logic [SLOT_W-1:0]  oslot_q;

  // Window scan
  ssd_state_e         state_q, state_d;
  logic [ROW_W-1:0]   row_q, r1_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [COL_W-1:0]   c0_q, c1_q;
  logic signed [XW-1:0] x_q;
  logic               s1v_q, s1lv_q, lv_q;
  logic [PIX_W-1:0]   l_q;
  logic [DISP_W-1:0]  k_q, bd_q;
  logic [ACC_W-1:0]   best_q;

  // Output register
  logic               ov_q;
  logic [CODE_W-1:0]  code_q;
  logic [COST_W-1:0]  cost_q;
  logic               fend_q;

  // Derived values
  logic [WID_W-1:0]   w_eff, wm1, c_top;
  logic [HGT_W-1:0]   h_eff, hm1, r_top;
  logic [ITEM_W-1:0]  total, lag, items_nx;
  logic [ROW_W-1:0]   r0, r1;
  logic [COL_W-1:0]   c0, c1;
  logic [SLOT_W-1:0]  rdist, slot_start, slot_nx, wr_slot_nx, oslot_nx;
  logic signed [XW-1:0] x_start, x_restart, c0_x, c1_x;
  logic [DISP_W-1:0]  maxd;
  logic               cfg_we, geom_we;
  logic               in_acc, frame_full, wr_en, ignore, start;
  logic               out_free, last_pix, scan_end, row_end;
  logic [COL_W-1:0]   rd_col;
  logic [PIX_W-1:0]   l_rd, r_rd;
  logic [PROD_W-1:0]  prod;
  logic [CODE_W-1:0]  code;
  logic               better;
  ssd_cell_ctrl_t     cell_ctrl;

  logic [PIX_W-1:0]   r_link   [DISPARITY_LIMIT];
  logic [ACC_W-1:0]   acc_link [DISPARITY_LIMIT];

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign geom_we = cfg_we & ((paddr[PADDR_W-1:2] == REG_FRAME_WIDTH) ||
                             (paddr[PADDR_W-1:2] == REG_FRAME_HEIGHT));

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_FRAME_WIDTH:   prdata = DATA_W'(fw_q);
      REG_FRAME_HEIGHT:  prdata = DATA_W'(fh_q);
      REG_MAX_DISPARITY: prdata = DATA_W'(md_q);
      REG_OUTPUT_SCALE:  prdata = DATA_W'(scale_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= FRAME_WIDTH_RST;
      fh_q    <= FRAME_HEIGHT_RST;
      md_q    <= MAX_DISPARITY_RST;
      scale_q <= OUTPUT_SCALE_RST;
    end else if (cfg_we) begin
      case (paddr[PADDR_W-1:2])
        REG_FRAME_WIDTH:   fw_q    <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:  fh_q    <= pwdata[FH_W-1:0];
        REG_MAX_DISPARITY: md_q    <= pwdata[MD_W-1:0];
        REG_OUTPUT_SCALE:  scale_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective geometry: clamp the registers to what the stores can hold
  // --------------------------------------------------------------------------
  always_comb begin
    if (fw_q == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(fh_q) > HEIGHT_LIMIT) begin
      h_eff = HGT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = HGT_W'(fh_q);
    end
    if (32'(md_q) > DISPARITY_LIMIT - 1) begin
      maxd = DISP_W'(DISPARITY_LIMIT - 1);
    end else begin
      maxd = DISP_W'(md_q);
    end
  end

  assign wm1   = w_eff - WID_W'(1);
  assign hm1   = h_eff - HGT_W'(1);
  assign total = ITEM_W'(w_eff) * ITEM_W'(h_eff);
  assign lag   = ITEM_W'(WINDOW_RADIUS) * ITEM_W'(w_eff) + ITEM_W'(WINDOW_RADIUS);

  // --------------------------------------------------------------------------
  // Input acceptance
  // --------------------------------------------------------------------------
  assign in_acc     = in_valid_i & in_ready_o;
  assign frame_full = (items_q >= total);
  assign ignore     = ~frame_full & is_padding_i;
  assign wr_en      = in_acc & ~frame_full & ~is_padding_i;
  assign items_nx   = items_q + ITEM_W'(1);
  assign start      = in_acc & ~ignore & (items_nx > lag);

  assign wr_slot_nx = (wr_slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : wr_slot_q + SLOT_W'(1);
  assign oslot_nx   = (oslot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : oslot_q + SLOT_W'(1);
  assign slot_nx    = (slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_q + SLOT_W'(1);

  // Clipped window of the current output pixel
  always_comb begin
    r0    = (orow_q >= ROW_W'(WINDOW_RADIUS)) ? orow_q - ROW_W'(WINDOW_RADIUS) : '0;
    r_top = HGT_W'(orow_q) + HGT_W'(WINDOW_RADIUS);
    r1    = (r_top > hm1) ? ROW_W'(hm1) : ROW_W'(r_top);
    c0    = (ocol_q >= COL_W'(WINDOW_RADIUS)) ? ocol_q - COL_W'(WINDOW_RADIUS) : '0;
    c_top = WID_W'(ocol_q) + WID_W'(WINDOW_RADIUS);
    c1    = (c_top > wm1) ? COL_W'(wm1) : COL_W'(c_top);
    rdist = SLOT_W'(orow_q - r0);
    if (oslot_q >= rdist) begin
      slot_start = oslot_q - rdist;
    end else begin
      slot_start = SLOT_W'(32'(oslot_q) + STORE_ROWS - 32'(rdist));
    end
    x_start = XW'(c0) - XW'(DISPARITY_LIMIT - 1);
  end

  assign c0_x      = XW'(c0_q);
  assign c1_x      = XW'(c1_q);
  assign x_restart = c0_x - XW'(DISPARITY_LIMIT - 1);
  assign row_end   = (x_q == c1_x);
  assign scan_end  = row_end & (row_q == r1_q);
  // Right pixels left of column 0 read column 0
  assign rd_col    = x_q[XW-1] ? '0 : x_q[COL_W-1:0];

  // --------------------------------------------------------------------------
  // Line stores
  // --------------------------------------------------------------------------
  ssd_line_store #(
    .ROWS  (STORE_ROWS),
    .WIDTH (MAX_WIDTH)
  ) u_left_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .wr_slot_i (wr_slot_q),
    .wr_col_i  (wr_col_q),
    .wr_data_i (left_pixel_i),
    .rd_slot_i (slot_q),
    .rd_col_i  (rd_col),
    .rd_data_o (l_rd)
  );

  ssd_line_store #(
    .ROWS  (STORE_ROWS),
    .WIDTH (MAX_WIDTH)
  ) u_right_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .wr_slot_i (wr_slot_q),
    .wr_col_i  (wr_col_q),
    .wr_data_i (right_pixel_i),
    .rd_slot_i (slot_q),
    .rd_col_i  (rd_col),
    .rd_data_o (r_rd)
  );

  // --------------------------------------------------------------------------
  // Row of disparity cells: cell d sees the right pixel d columns behind the
  // left pixel broadcast to all of them, and accumulates its squared error.
  // In the unload step the costs move towards cell 0, lowest disparity first.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DISPARITY_LIMIT; k++) begin : g_cell
    logic [PIX_W-1:0] r_in;
    logic [ACC_W-1:0] acc_in;
    if (k == 0) begin : g_head
      assign r_in = r_rd;
    end else begin : g_body
      assign r_in = r_link[k-1];
    end
    if (k == DISPARITY_LIMIT - 1) begin : g_tail
      assign acc_in = '0;
    end else begin : g_mid
      assign acc_in = acc_link[k+1];
    end
    ssd_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .r_i    (r_in),
      .acc_i  (acc_in),
      .r_o    (r_link[k]),
      .acc_o  (acc_link[k])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = ~ov_q | out_ready_i;
  assign last_pix = (HGT_W'(orow_q) == hm1) & (WID_W'(ocol_q) == wm1);
  assign better   = (k_q <= maxd) & (acc_link[0] <= best_q);
  assign prod     = PROD_W'(bd_q) * PROD_W'(scale_q);
  assign code     = (prod > PROD_W'(255)) ? CODE_W'(255) : prod[CODE_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_SCAN;
      ST_SCAN:  if (scan_end) state_d = ST_DRAIN;
      ST_DRAIN: if (!s1v_q && !lv_q) state_d = ST_SHIFT;
      ST_SHIFT: if (k_q == DISP_W'(DISPARITY_LIMIT - 1)) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o          = (state_q == ST_IDLE);
    cell_ctrl.clear     = (state_q == ST_IDLE);
    cell_ctrl.acc_en    = lv_q;
    cell_ctrl.r_shift   = s1v_q;
    cell_ctrl.shift_out = (state_q == ST_SHIFT);
    cell_ctrl.l_pix     = l_q;
  end

  // Read pipeline: address, store data, broadcast
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q  <= 1'b0;
      s1lv_q <= 1'b0;
      lv_q   <= 1'b0;
    end else begin
      s1v_q  <= (state_q == ST_SCAN);
      s1lv_q <= (state_q == ST_SCAN) && (x_q >= c0_x);
      lv_q   <= s1v_q & s1lv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= l_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window scan and unload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        row_q  <= r0;
        r1_q   <= r1;
        slot_q <= slot_start;
        c0_q   <= c0;
        c1_q   <= c1;
        x_q    <= x_start;
      end
      ST_SCAN: begin
        if (row_end) begin
          row_q  <= row_q + ROW_W'(1);
          slot_q <= slot_nx;
          x_q    <= x_restart;
        end else begin
          x_q <= x_q + XW'(1);
        end
      end
      ST_DRAIN: begin
        k_q    <= '0;
        bd_q   <= '0;
        best_q <= '1;
      end
      ST_SHIFT: begin
        k_q <= k_q + DISP_W'(1);
        // Ties go to the larger disparity
        if (better) begin
          best_q <= acc_link[0];
          bd_q   <= k_q;
        end
      end
      default: ;
    endcase
  end

  // Frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q   <= '0;
      wr_col_q  <= '0;
      wr_slot_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      oslot_q   <= '0;
    end else if (geom_we) begin
      // Drop the frame in progress
      items_q   <= '0;
      wr_col_q  <= '0;
      wr_slot_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      oslot_q   <= '0;
    end else begin
      if (wr_en) begin
        if (WID_W'(wr_col_q) + WID_W'(1) >= w_eff) begin
          wr_col_q  <= '0;
          wr_slot_q <= wr_slot_nx;
        end else begin
          wr_col_q <= wr_col_q + COL_W'(1);
        end
      end
      if (in_acc && !ignore) begin
        items_q <= items_nx;
      end
      if (state_q == ST_DONE && out_free) begin
        if (last_pix) begin
          items_q   <= '0;
          wr_col_q  <= '0;
          wr_slot_q <= '0;
          orow_q    <= '0;
          ocol_q    <= '0;
          oslot_q   <= '0;
        end else if (WID_W'(ocol_q) == wm1) begin
          ocol_q  <= '0;
          orow_q  <= orow_q + ROW_W'(1);
          oslot_q <= oslot_nx;
        end else begin
          ocol_q <= ocol_q + COL_W'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      ov_q <= 1'b1;
    end else if (ov_q && out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      code_q <= code;
      cost_q <= COST_W'(best_q);
      fend_q <= last_pix;
    end
  end

  assign out_valid_o      = ov_q;
  assign disparity_code_o = code_q;
  assign best_cost_o      = cost_q;
  assign frame_end_o      = fend_q;

endmodule

// File: tb/sv/ssd_stereo_disparity_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_stereo_disparity_core_tb
// Self-checking bench: small frames of pixel pairs go in, and each disparity
// result is compared against an in-bench window-SSD search over the frame.
// ----------------------------------------------------------------------------
module ssd_stereo_disparity_core_tb;
  import ssd_pkg::*;

  localparam int RADIUS     = WINDOW_RADIUS_DEF;
  localparam int WIDTH_CAP  = MAX_WIDTH_DEF;
  localparam int DISP_CAP   = DISPARITY_LIMIT_DEF;
  localparam int ITEM_GOAL  = 1250;
  localparam int SETTLE     = 40;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [COST_W-1:0] cost;
    logic              last;
  } disparity_t;

  // Holds the register copy, the pixels of the current frame and the queue of
  // disparity results still owed by the core.
  class disparity_scoreboard;
    int unsigned width_reg, height_reg, maxd_reg, scale_reg;
    int unsigned taken, out_row, out_col;
    byte unsigned left_px[$], right_px[$];
    disparity_t owed[$];
    int mismatches;

    function new();
      width_reg = FRAME_WIDTH_RST; height_reg = FRAME_HEIGHT_RST;
      maxd_reg = MAX_DISPARITY_RST; scale_reg = OUTPUT_SCALE_RST;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      taken = 0; out_row = 0; out_col = 0;
      left_px.delete(); right_px.delete();
    endfunction

    function int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > WIDTH_CAP) return WIDTH_CAP;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < 1) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = val[FW_W-1:0]; restart();
        end
        REG_FRAME_HEIGHT: begin
          height_reg = val[FH_W-1:0]; restart();
        end
        REG_MAX_DISPARITY: maxd_reg = val[MD_W-1:0];
        default: scale_reg = val[SCALE_W-1:0];
      endcase
    endfunction

    // Search every disparity over the clipped window; ties favour larger d.
    function disparity_t search(int unsigned r, int unsigned c);
      disparity_t res;
      int unsigned w, h, r0, r1, c0, c1, best_d, code, cost, best;
      int lp, rp;
      w = eff_w(); h = eff_h();
      r0 = (r >= RADIUS) ? r - RADIUS : 0;
      r1 = (r + RADIUS > h - 1) ? h - 1 : r + RADIUS;
      c0 = (c >= RADIUS) ? c - RADIUS : 0;
      c1 = (c + RADIUS > w - 1) ? w - 1 : c + RADIUS;
      best = 32'hffff_ffff; best_d = 0;
      for (int unsigned d = 0; d <= maxd_reg && d < DISP_CAP; d++) begin
        cost = 0;
        for (int unsigned i = r0; i <= r1; i++)
          for (int unsigned j = c0; j <= c1; j++) begin
            lp = left_px[i*w + j];
            rp = right_px[i*w + ((j >= d) ? j - d : 0)];
            cost += (lp - rp) * (lp - rp);
          end
        if (cost <= best) begin
          best = cost; best_d = d;
        end
      end
      code = best_d * scale_reg;
      res.code = (code > 255) ? 8'd255 : code[7:0];
      res.cost = best[COST_W-1:0];
      res.last = (r == h - 1) && (c == w - 1);
      return res;
    endfunction

    function void note_input(byte unsigned l, byte unsigned rpx, bit pad);
      int unsigned w, h;
      disparity_t res;
      w = eff_w(); h = eff_h();
      if (taken < w * h) begin
        if (pad) return;
        left_px = {left_px, l}; right_px = {right_px, rpx};
      end
      taken++;
      if (taken <= RADIUS * w + RADIUS) return;
      res = search(out_row, out_col);
      owed = {owed, res};
      if (res.last) restart();
      else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0; out_row++;
        end
      end
    endfunction

    function void check_result(logic [CODE_W-1:0] code, logic [COST_W-1:0] cost,
                               logic last);
      disparity_t exp_r;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result code=%0d cost=%0d end=%0b", code, cost, last);
        return;
      end
      exp_r = owed.pop_front();
      if (code !== exp_r.code || cost !== exp_r.cost || last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp code=%0d cost=%0d end=%0b, got %0d %0d %0b",
                   exp_r.code, exp_r.cost, exp_r.last, code, cost, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PIX_W-1:0] left_pixel_i = '0, right_pixel_i = '0;
  logic is_padding_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CODE_W-1:0] disparity_code_o;
  logic [COST_W-1:0] best_cost_o;
  logic frame_end_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  disparity_scoreboard sb = new();
  int send_idle = 9, recv_idle = 73;
  int items_sent = 0;
  longint cycles = 0;

  ssd_stereo_disparity_core dut (.*);

  always #4 clk_i = ~clk_i;

  // Receiver side: check on each handshake, stall at random per phase.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(disparity_code_o, best_cost_o, frame_end_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: fail and end the run if it runs past its overall time limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one item and hold it until the core takes it.
  task automatic send_item(byte unsigned l, byte unsigned rpx, bit pad);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_pixel_i <= l; right_pixel_i <= rpx; is_padding_i <= pad;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(l, rpx, pad);
    items_sent++;
    // advance the idling phase by the item count
    if (items_sent == ITEM_GOAL / 3) begin
      send_idle = 73; recv_idle = 9;
    end else if (items_sent == 2 * ITEM_GOAL / 3) begin
      send_idle = 0; recv_idle = 0;
    end
  endtask

  // Wait for every owed result, then let any trailing no-result item drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Setup phase, access phase, then an idle gap before the next transfer.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Feed one frame: pixels with stray padding inside, then the flush unless broken.
  // The right image is the left one shifted by a random disparity plus noise.
  task automatic run_frame(int unsigned w, int unsigned h, bit broken);
    byte unsigned lrow[];
    int unsigned sh, noise, cut, lag;
    int v;
    lrow = new[w * h];
    sh = $urandom_range(w);
    noise = $urandom_range(3) == 0 ? 255 : $urandom_range(6);
    lag = RADIUS * w + RADIUS;
    cut = broken ? $urandom_range(w * h) : w * h;
    if (broken && cut > lag) cut = lag;
    foreach (lrow[k]) lrow[k] = 8'($urandom_range(255));
    for (int unsigned k = 0; k < cut; k++) begin
      if ($urandom_range(15) == 0) send_item(8'($urandom), 8'($urandom), 1'b1);
      v = lrow[(k / w) * w + (((k % w) + sh < w) ? (k % w) + sh : w - 1)];
      v = v + $urandom_range(noise) - noise / 2;
      v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      send_item(lrow[k], 8'(v), 1'b0);
    end
    // drop the frame part-way; the next geometry write abandons it
    if (broken) return;
    for (int unsigned k = 0; k < lag; k++)
      send_item(8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned w, h;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // Out-of-range geometry clamps: the widest and tallest settings are
    // written and then replaced before any pixel goes in.
    write_reg(REG_FRAME_WIDTH, 32'd2047);
    write_reg(REG_FRAME_HEIGHT, 32'd2047);
    write_reg(REG_FRAME_WIDTH, 32'd1024);
    // Single-pixel frame from zero geometry, largest disparity and scale:
    // every disparity reads column 0, so all tie and the code saturates.
    write_reg(REG_FRAME_WIDTH, 32'd0);
    write_reg(REG_FRAME_HEIGHT, 32'd0);
    write_reg(REG_MAX_DISPARITY, 32'd127);
    write_reg(REG_OUTPUT_SCALE, 32'd255);
    send_item(8'd0, 8'd255, 1'b1);  // padding inside the frame is ignored
    send_item(8'd255, 8'd0, 1'b0);
    for (int k = 0; k < 2 * RADIUS; k++) send_item(8'hff, 8'hff, k[0]);
    wait_idle();
    // Two-by-two frame, no search and zero scale.
    write_reg(REG_FRAME_WIDTH, 32'd2);
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    write_reg(REG_MAX_DISPARITY, 32'd0);
    write_reg(REG_OUTPUT_SCALE, 32'd0);
    run_frame(2, 2, 1'b0);
    wait_idle();

    // Random frames, mostly small so each result stays cheap.
    while (items_sent < ITEM_GOAL) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
      h = (w > 8) ? $urandom_range(2, 1) : $urandom_range(6, 1);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      case ($urandom_range(3))
        0: write_reg(REG_MAX_DISPARITY, 32'd0);
        1: write_reg(REG_MAX_DISPARITY, 32'd127);
        default: write_reg(REG_MAX_DISPARITY, $urandom);
      endcase
      write_reg(REG_OUTPUT_SCALE, ($urandom_range(4) == 0) ? 32'd255 : $urandom);
      run_frame(w, h, $urandom_range(7) == 0);
      wait_idle();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
